// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, switched off while reset is high
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m assertion failed");

// concurrent assertion that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m assertion failed");

`endif

// ===== sv/dlm_pkg.sv =====
// ----------------------------------------------------------------------------
// dlm_pkg
// Types, constants and helper functions of the disc read latency model.
// ----------------------------------------------------------------------------
package dlm_pkg;

   localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;
   localparam logic [31:0] BLOCK_BYTES = 32'h0001_0000;
   localparam logic [31:0] CACHE_BYTES = 32'h0010_0000;
   localparam logic [31:0] BLOCK_MASK  = BLOCK_BYTES - 32'd1;

   localparam int ADDR_W = 5;

   localparam logic [2:0] REG_LIMIT_ENABLE     = 3'd0;
   localparam logic [2:0] REG_SEEK_TICKS       = 3'd1;
   localparam logic [2:0] REG_READ_BYTES_TICK  = 3'd2;
   localparam logic [2:0] REG_READ_TICKS_BYTE  = 3'd3;
   localparam logic [2:0] REG_CACHE_TICKS_BYTE = 3'd4;

   localparam logic        RST_LIMIT_ENABLE     = 1'b1;
   localparam logic [31:0] RST_SEEK_TICKS       = 32'd94922;
   localparam logic [23:0] RST_READ_BYTES_TICK  = 24'd108593;
   localparam logic [23:0] RST_READ_TICKS_BYTE  = 24'd39551;
   localparam logic [23:0] RST_CACHE_TICKS_BYTE = 24'd7597;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_MOTOR = 2'd1;
   localparam logic [1:0] OP_SETUP = 2'd2;
   localparam logic [1:0] OP_END   = 2'd3;

   typedef struct packed {
      logic        limit_enable;
      logic [31:0] seek_cost;
      logic [23:0] read_bytes_per_tick;
      logic [23:0] disc_ticks_per_byte;
      logic [23:0] cache_ticks_per_byte;
   } cfg_type;

   function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? ALL_ONES : s[31:0];
   endfunction

   function automatic logic [31:0] scale_sat(input logic [55:0] p);
      return (p[55:48] != 8'd0) ? ALL_ONES : p[47:16];
   endfunction

   function automatic logic [31:0] align_down(input logic [31:0] a);
      return a & ~BLOCK_MASK;
   endfunction

   function automatic logic [31:0] elapsed_ticks(input logic [31:0] stamp,
                                                 input logic [31:0] now);
      return (stamp > now) ? ALL_ONES : (now - stamp);
   endfunction

endpackage

// ===== sv/disc_read_latency_model.sv =====
// sequence: start, motor, end query and disabled setup pass through EXEC and FIN before
// rsp_valid is raised; a setup that misses the read-ahead window also passes MUL0 and MISS,
// and one inside the window MUL0, CACHE, MUL1, MUL2 and SUM, set by the shared multiplier.
// throughput: one transaction at a time; a result stall in FIN holds off the next one.
// synchronous reset clears the drive state and loads the register defaults.
// ----------------------------------------------------------------------------
// disc_read_latency_model
// Sequencer around one shared multiplier that estimates disc read timing.
// ----------------------------------------------------------------------------
module disc_read_latency_model (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_opcode,
   input  logic [31:0]                 req_now_time,
   input  logic [31:0]                 req_offset,
   input  logic [30:0]                 req_length,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [31:0]                 rsp_xfer_ticks,
   output logic                        rsp_done_res,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [dlm_pkg::ADDR_W-1:0]  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import dlm_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_EXEC  = 4'd1;
   localparam logic [3:0] ST_MUL0  = 4'd2;
   localparam logic [3:0] ST_MISS  = 4'd3;
   localparam logic [3:0] ST_CACHE = 4'd4;
   localparam logic [3:0] ST_MUL1  = 4'd5;
   localparam logic [3:0] ST_MUL2  = 4'd6;
   localparam logic [3:0] ST_SUM   = 4'd7;
   localparam logic [3:0] ST_FIN   = 4'd8;

   cfg_type     cfg;
   logic [31:0] mul_a;
   logic [23:0] mul_b;
   logic [31:0] mul_scaled;

   logic [3:0]  state_ff, state_in;
   logic [1:0]  op_ff, op_in;
   logic [31:0] now_ff, now_in;
   logic [31:0] off_ff, off_in;
   logic [30:0] len_ff, len_in;
   logic [31:0] cur_ff, cur_in;
   logic        miss_ff, miss_in;
   logic [31:0] el_ff, el_in;
   logic [30:0] take_ff, take_in;
   logic [30:0] rem_ff, rem_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] res_ticks_ff, res_ticks_in;
   logic        res_done_ff, res_done_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_ticks_ff, rsp_ticks_in;
   logic        rsp_done_ff, rsp_done_in;
   logic [31:0] start_time_ff, start_time_in;
   logic [31:0] last_finish_ff, last_finish_in;
   logic [31:0] pending_ff, pending_in;
   logic [31:0] base_ff, base_in;
   logic [31:0] last_block_ff, last_block_in;

   logic [31:0] cached_w;
   logic [31:0] upto_w;
   logic [31:0] usable_w;
   logic [31:0] end_addr_w;
   logic [31:0] rem_end_w;

   dlm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dlm_mul u_mul (
      .clock      (clock),
      .mul_a      (mul_a),
      .mul_b      (mul_b),
      .mul_scaled (mul_scaled)
   );

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_xfer_ticks = rsp_ticks_ff;
   assign rsp_done_res   = rsp_done_ff;

   assign cached_w   = (mul_scaled > CACHE_BYTES) ? CACHE_BYTES : mul_scaled;
   assign upto_w     = base_ff + BLOCK_BYTES + cached_w;
   assign usable_w   = upto_w - cur_ff;
   assign end_addr_w = off_ff + {1'b0, len_ff};
   assign rem_end_w  = off_ff + {1'b0, rem_ff};

   always_comb begin
      case (state_ff)
         ST_MUL0: begin
            mul_a = miss_ff ? {1'b0, len_ff} : el_ff;
            mul_b = miss_ff ? cfg.disc_ticks_per_byte : cfg.read_bytes_per_tick;
         end
         ST_MUL1: begin
            mul_a = {1'b0, take_ff};
            mul_b = cfg.cache_ticks_per_byte;
         end
         ST_MUL2: begin
            mul_a = {1'b0, rem_ff};
            mul_b = cfg.disc_ticks_per_byte;
         end
         default: begin
            mul_a = 32'd0;
            mul_b = 24'd0;
         end
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      now_in         = now_ff;
      off_in         = off_ff;
      len_in         = len_ff;
      cur_in         = cur_ff;
      miss_in        = miss_ff;
      el_in          = el_ff;
      take_in        = take_ff;
      rem_in         = rem_ff;
      acc_in         = acc_ff;
      res_ticks_in   = res_ticks_ff;
      res_done_in    = res_done_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_ticks_in   = rsp_ticks_ff;
      rsp_done_in    = rsp_done_ff;
      start_time_in  = start_time_ff;
      last_finish_in = last_finish_ff;
      pending_in     = pending_ff;
      base_in        = base_ff;
      last_block_in  = last_block_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_opcode;
               now_in   = req_now_time;
               off_in   = req_offset;
               len_in   = req_length;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_ticks_in = 32'd0;
            res_done_in  = 1'b0;
            state_in     = ST_FIN;
            case (op_ff)
               OP_START: begin
                  if (cfg.limit_enable) begin
                     start_time_in = now_ff;
                  end
               end
               OP_MOTOR: begin
                  if (cfg.limit_enable) begin
                     start_time_in = now_ff;
                     pending_in    = cfg.seek_cost;
                  end
               end
               OP_SETUP: begin
                  if (cfg.limit_enable) begin
                     cur_in   = align_down(off_ff);
                     miss_in  = (align_down(off_ff) < base_ff) ||
                                ((end_addr_w - base_ff) > CACHE_BYTES);
                     el_in    = elapsed_ticks(last_finish_ff, now_ff);
                     state_in = ST_MUL0;
                  end
               end
               OP_END: begin
                  res_done_in = 1'b1;
                  if (cfg.limit_enable && (pending_ff != ALL_ONES)) begin
                     if (elapsed_ticks(start_time_ff, now_ff) < pending_ff) begin
                        res_done_in = 1'b0;
                     end else begin
                        pending_in = ALL_ONES;
                        if (last_block_ff != base_ff) begin
                           last_block_in  = base_ff;
                           last_finish_in = now_ff;
                        end
                     end
                  end
               end
               default: begin
                  state_in = ST_FIN;
               end
            endcase
         end
         ST_MUL0: begin
            state_in = miss_ff ? ST_MISS : ST_CACHE;
         end
         ST_MISS: begin
            res_ticks_in = add_sat(mul_scaled, cfg.seek_cost);
            pending_in   = add_sat(mul_scaled, cfg.seek_cost);
            base_in      = align_down(end_addr_w);
            state_in     = ST_FIN;
         end
         ST_CACHE: begin
            if (upto_w > cur_ff) begin
               take_in = ({1'b0, len_ff} < usable_w) ? len_ff : usable_w[30:0];
               rem_in  = len_ff - (({1'b0, len_ff} < usable_w) ? len_ff : usable_w[30:0]);
            end else begin
               take_in = 31'd0;
               rem_in  = len_ff;
            end
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            acc_in   = mul_scaled;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            res_ticks_in = add_sat(acc_ff, mul_scaled);
            pending_in   = add_sat(acc_ff, mul_scaled);
            if ((cur_ff - base_ff) > BLOCK_BYTES) begin
               base_in = align_down(rem_end_w);
            end
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_ticks_in = res_ticks_ff;
               rsp_done_in  = res_done_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         start_time_ff  <= 32'd0;
         last_finish_ff <= 32'd0;
         pending_ff     <= ALL_ONES;
         base_ff        <= ALL_ONES;
         last_block_ff  <= ALL_ONES;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         start_time_ff  <= start_time_in;
         last_finish_ff <= last_finish_in;
         pending_ff     <= pending_in;
         base_ff        <= base_in;
         last_block_ff  <= last_block_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      now_ff       <= now_in;
      off_ff       <= off_in;
      len_ff       <= len_in;
      cur_ff       <= cur_in;
      miss_ff      <= miss_in;
      el_ff        <= el_in;
      take_ff      <= take_in;
      rem_ff       <= rem_in;
      acc_ff       <= acc_in;
      res_ticks_ff <= res_ticks_in;
      res_done_ff  <= res_done_in;
      rsp_ticks_ff <= rsp_ticks_in;
      rsp_done_ff  <= rsp_done_in;
   end

endmodule

// ===== sv/dlm_csr.sv =====
// ----------------------------------------------------------------------------
// dlm_csr
// APB register file holding the timing configuration.
// ----------------------------------------------------------------------------
module dlm_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [dlm_pkg::ADDR_W-1:0]  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready,
   output dlm_pkg::cfg_type            cfg
);
   import dlm_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   logic [2:0]  reg_idx;
   logic        wr_en;

   assign reg_idx = paddr[ADDR_W-1:2];
   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite & pready;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_LIMIT_ENABLE:     cfg_in.limit_enable         = pwdata[0];
            REG_SEEK_TICKS:       cfg_in.seek_cost            = pwdata;
            REG_READ_BYTES_TICK:  cfg_in.read_bytes_per_tick  = pwdata[23:0];
            REG_READ_TICKS_BYTE:  cfg_in.disc_ticks_per_byte  = pwdata[23:0];
            REG_CACHE_TICKS_BYTE: cfg_in.cache_ticks_per_byte = pwdata[23:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_LIMIT_ENABLE:     prdata = {31'd0, cfg_ff.limit_enable};
         REG_SEEK_TICKS:       prdata = cfg_ff.seek_cost;
         REG_READ_BYTES_TICK:  prdata = {8'd0, cfg_ff.read_bytes_per_tick};
         REG_READ_TICKS_BYTE:  prdata = {8'd0, cfg_ff.disc_ticks_per_byte};
         REG_CACHE_TICKS_BYTE: prdata = {8'd0, cfg_ff.cache_ticks_per_byte};
         default:              prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.limit_enable         <= RST_LIMIT_ENABLE;
         cfg_ff.seek_cost            <= RST_SEEK_TICKS;
         cfg_ff.read_bytes_per_tick  <= RST_READ_BYTES_TICK;
         cfg_ff.disc_ticks_per_byte  <= RST_READ_TICKS_BYTE;
         cfg_ff.cache_ticks_per_byte <= RST_CACHE_TICKS_BYTE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== sv/dlm_mul.sv =====
// ----------------------------------------------------------------------------
// dlm_mul
// Shared 32x24 multiplier with registered product and Q8.16 scaling.
// ----------------------------------------------------------------------------
module dlm_mul (
   input  logic        clock,
   input  logic [31:0] mul_a,
   input  logic [23:0] mul_b,
   output logic [31:0] mul_scaled
);
   import dlm_pkg::*;

   logic [55:0] prod_ff;
   logic [55:0] prod_in;

   assign prod_in    = {24'd0, mul_a} * {32'd0, mul_b};
   assign mul_scaled = scale_sat(prod_ff);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== sv/dlm_checker.sv =====
// ----------------------------------------------------------------------------
// dlm_checker
// Port-level checks of the disc read latency model, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dlm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_xfer_ticks,
   input logic        rsp_done_res,
   input logic        pready
);

   // result transaction held while stalled
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_xfer_ticks) && $stable(rsp_done_res))

   // sequencer is busy right after taking a transaction
   `ASSERT_CLK(a_busy_after_accept, clock, reset, req_valid && !req_stall |=> req_stall)

   // only a setup carries ticks, only an end query reports done
   `ASSERT_CLK(a_result_exclusive, clock, reset, rsp_valid |-> !(rsp_done_res && (rsp_xfer_ticks != 32'd0)))

   // no result right after reset
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid && !req_stall)

   // register port never waits
   `ASSERT_ALWAYS(a_pready_high, clock, pready)

endmodule

bind disc_read_latency_model dlm_checker u_dlm_checker (.*);

// ===== bench/disc_read_latency_model_tb.sv =====
// ----------------------------------------------------------------------------
// disc_read_latency_model_tb
// Self-checking bench for the disc read latency model. A short directed table
// covers reset state, window hits and misses, cache saturation, timer wrap,
// saturated setups and disabled timing. Random phases then reprogram every
// register and run drive transfers (spin-up, setups near the read-ahead
// window, end queries around the due time) mixed with noise. Every result
// transaction is compared with a local timing predictor. The sender idles in
// bursts and the receiver stalls on a rotating pattern.
// ----------------------------------------------------------------------------
module disc_read_latency_model_tb;
   import dlm_pkg::*;

   localparam int PHASES      = 11;
   localparam int PHASE_ITEMS = 50;
   localparam int SETTLE_CYC  = 12;
   localparam int IDLE_LIMIT  = 4000;
   localparam int REPORT_CAP  = 100;

   typedef struct {
      logic        is_cfg;
      logic [2:0]  reg_sel;
      logic [31:0] value;
      logic [1:0]  op;
      logic [31:0] now;
      logic [31:0] off;
      logic [30:0] len;
      logic        typed;
      logic [31:0] exp_ticks;
      logic        exp_done;
   } command_type;

   typedef struct {
      logic [31:0] ticks;
      logic        done;
   } timing_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = '0;
   logic [31:0] req_now_time = '0;
   logic [31:0] req_offset = '0;
   logic [30:0] req_length = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_xfer_ticks;
   logic        rsp_done_res;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   disc_read_latency_model u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_now_time   (req_now_time),
      .req_offset     (req_offset),
      .req_length     (req_length),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_xfer_ticks (rsp_xfer_ticks),
      .rsp_done_res   (rsp_done_res),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor copy of the registers and the drive state
   logic        lim_en;
   logic [31:0] seek;
   logic [23:0] disc_bpt;
   logic [23:0] disc_tpb;
   logic [23:0] cache_tpb;
   logic [31:0] t_start;
   logic [31:0] t_finish;
   logic [31:0] ticks_owed;
   logic [31:0] window_base;
   logic [31:0] finished_block;

   timing_type  expected_timings[$];
   command_type directed_rows[$];

   int errors = 0;
   int items_sent = 0;
   int setups_hit = 0;
   int setups_missed = 0;
   int ends_done = 0;
   int ends_waiting = 0;
   int csr_writes = 0;
   int burst_left = 0;
   int idle_cycles = 0;
   logic [31:0] drive_now = '0;

   function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? ALL_ONES : s[31:0];
   endfunction

   function automatic logic [31:0] rate_mul(input logic [31:0] n, input logic [23:0] q);
      logic [63:0] p;
      p = ({32'd0, n} * {40'd0, q}) >> 16;
      return (p[63:32] != 32'd0) ? ALL_ONES : p[31:0];
   endfunction

   function automatic logic [31:0] block_floor(input logic [31:0] a);
      return a - (a % BLOCK_BYTES);
   endfunction

   function automatic logic [31:0] since(input logic [31:0] stamp, input logic [31:0] now);
      return (stamp > now) ? ALL_ONES : now - stamp;
   endfunction

   function automatic void predict_read_timing(input logic [1:0] op, input logic [31:0] now,
                                               input logic [31:0] off, input logic [30:0] len,
                                               output timing_type res);
      logic [31:0] cur;
      logic [31:0] span;
      logic [31:0] cached;
      logic [31:0] upto;
      logic [31:0] usable;
      logic [31:0] take;
      logic [31:0] left;
      res.ticks = '0;
      res.done  = 1'b0;
      case (op)
         OP_START: begin
            if (lim_en) t_start = now;
         end
         OP_MOTOR: begin
            if (lim_en) begin
               t_start    = now;
               ticks_owed = seek;
            end
         end
         OP_SETUP: begin
            if (lim_en) begin
               left = {1'b0, len};
               cur  = block_floor(off);
               span = off + left - window_base;
               if (cur < window_base || span > CACHE_BYTES) begin
                  res.ticks   = sat_sum(rate_mul(left, disc_tpb), seek);
                  window_base = block_floor(off + left);
                  setups_missed++;
               end else begin
                  cached = rate_mul(since(t_finish, now), disc_bpt);
                  if (cached > CACHE_BYTES) cached = CACHE_BYTES;
                  upto = window_base + BLOCK_BYTES + cached;
                  if (upto > cur) begin
                     usable = upto - cur;
                     take   = (left < usable) ? left : usable;
                     if (take != 0) begin
                        res.ticks = sat_sum(res.ticks, rate_mul(take, cache_tpb));
                        left      = left - take;
                     end
                  end
                  if (left != 0) res.ticks = sat_sum(res.ticks, rate_mul(left, disc_tpb));
                  if (cur - window_base > BLOCK_BYTES) window_base = block_floor(off + left);
                  setups_hit++;
               end
               ticks_owed = res.ticks;
            end
         end
         default: begin
            res.done = 1'b1;
            if (lim_en && ticks_owed != ALL_ONES) begin
               if (since(t_start, now) < ticks_owed) begin
                  res.done = 1'b0;
               end else begin
                  ticks_owed = ALL_ONES;
                  if (finished_block != window_base) begin
                     finished_block = window_base;
                     t_finish       = now;
                  end
               end
            end
            if (res.done) ends_done++;
            else ends_waiting++;
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (errors < REPORT_CAP)
         $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
      errors++;
   endtask

   task automatic csr_write(input logic [2:0] reg_sel, input logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (reg_sel)
         REG_LIMIT_ENABLE:     lim_en    = value[0];
         REG_SEEK_TICKS:       seek      = value;
         REG_READ_BYTES_TICK:  disc_bpt  = value[23:0];
         REG_READ_TICKS_BYTE:  disc_tpb  = value[23:0];
         REG_CACHE_TICKS_BYTE: cache_tpb = value[23:0];
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_timings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic issue_command(input command_type c);
      int         gap;
      timing_type res;
      if (c.is_cfg) begin
         settle_block();
         csr_write(c.reg_sel, c.value);
      end else begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
               @(negedge clock);
               req_valid <= 1'b0;
               repeat (gap - 1) @(negedge clock);
            end
         end
         burst_left--;
         @(negedge clock);
         req_valid    <= 1'b1;
         req_opcode   <= c.op;
         req_now_time <= c.now;
         req_offset   <= c.off;
         req_length   <= c.len;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         predict_read_timing(c.op, c.now, c.off, c.len, res);
         if (c.typed) begin
            res.ticks = c.exp_ticks;
            res.done  = c.exp_done;
         end
         expected_timings.push_back(res);
         items_sent++;
      end
   endtask

   task automatic send_cmd(input logic [1:0] op, input logic [31:0] now,
                           input logic [31:0] off, input logic [30:0] len);
      command_type c;
      c = '{1'b0, 3'd0, 32'd0, op, now, off, len, 1'b0, 32'd0, 1'b0};
      issue_command(c);
   endtask

   task automatic add_row(input logic [1:0] op, input logic [31:0] now,
                          input logic [31:0] off, input logic [30:0] len);
      directed_rows.push_back('{1'b0, 3'd0, 32'd0, op, now, off, len, 1'b0, 32'd0, 1'b0});
   endtask

   task automatic add_typed(input logic [1:0] op, input logic [31:0] now,
                            input logic [31:0] off, input logic [30:0] len,
                            input logic [31:0] ticks, input logic done);
      directed_rows.push_back('{1'b0, 3'd0, 32'd0, op, now, off, len, 1'b1, ticks, done});
   endtask

   task automatic add_cfg(input logic [2:0] reg_sel, input logic [31:0] value);
      directed_rows.push_back('{1'b1, reg_sel, value, OP_START, 32'd0, 32'd0, 31'd0,
                                1'b0, 32'd0, 1'b0});
   endtask

   function automatic logic [31:0] pick_offset();
      case ($urandom_range(0, 7))
         0:       return $urandom;
         1:       return $urandom_range(0, 32'h0100_0000);
         2:       return window_base - $urandom_range(1, 32'h0002_0000);
         default: begin
            if (window_base == ALL_ONES) return $urandom_range(0, 32'h0100_0000);
            return window_base + $urandom_range(0, 32'h0014_0000);
         end
      endcase
   endfunction

   function automatic logic [30:0] pick_length();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 9))
         0:       return '0;
         6, 7, 8: return 31'($urandom_range(1, 32'h0004_0000));
         9:       return r[30:0];
         default: return 31'($urandom_range(1, 32'h0000_8000));
      endcase
   endfunction

   function automatic logic [31:0] pick_end_time();
      logic [31:0] t;
      if (ticks_owed == ALL_ONES) begin
         t = drive_now + $urandom_range(0, 100000);
      end else begin
         case ($urandom_range(0, 3))
            0:       t = t_start + ticks_owed - 32'd1;
            1:       t = t_start + ticks_owed;
            2:       t = t_start + $urandom_range(0, ticks_owed);
            default: t = t_start + ticks_owed + $urandom_range(0, 100000);
         endcase
      end
      if (t > drive_now) drive_now = t;
      return t;
   endfunction

   task automatic run_transfer();
      int n_setups;
      int n_ends;
      drive_now = drive_now + $urandom_range(0, 300000);
      send_cmd($urandom_range(0, 1) ? OP_MOTOR : OP_START, drive_now, $urandom,
               31'($urandom));
      n_setups = $urandom_range(1, 3);
      repeat (n_setups) begin
         drive_now = drive_now + $urandom_range(0, 50000);
         send_cmd(OP_SETUP, drive_now, pick_offset(), pick_length());
         n_ends = $urandom_range(1, 3);
         repeat (n_ends) send_cmd(OP_END, pick_end_time(), $urandom, 31'($urandom));
      end
   endtask

   function automatic logic [23:0] pick_rate(input int ph, input logic [23:0] dflt);
      if (ph == 1) return '0;
      if (ph == 2) return 24'hFF_FFFF;
      if ($urandom_range(0, 3) == 0) return 24'($urandom_range(0, 24'hFF_FFFF));
      return 24'($urandom_range(dflt / 4, dflt * 4));
   endfunction

   task automatic program_phase(input int ph);
      logic [31:0] seek_val;
      if (ph == 1) seek_val = '0;
      else if (ph == 2) seek_val = ALL_ONES;
      else if ($urandom_range(0, 5) == 0) seek_val = $urandom;
      else seek_val = $urandom_range(0, 200000);
      settle_block();
      csr_write(REG_LIMIT_ENABLE, (ph == 3 || $urandom_range(0, 9) == 0) ? 32'd0 : 32'd1);
      csr_write(REG_SEEK_TICKS, seek_val);
      csr_write(REG_READ_BYTES_TICK, {8'd0, pick_rate(ph, RST_READ_BYTES_TICK)});
      csr_write(REG_READ_TICKS_BYTE, {8'd0, pick_rate(ph, RST_READ_TICKS_BYTE)});
      csr_write(REG_CACHE_TICKS_BYTE, {8'd0, pick_rate(ph, RST_CACHE_TICKS_BYTE)});
   endtask

   // receiver stall pattern, reloaded whenever the 6-bit age counter wraps
   logic [15:0] stall_bits = '0;
   logic [5:0]  stall_age = '0;

   always @(negedge clock) begin
      stall_age <= stall_age + 6'd1;
      if (stall_age == 6'd0) begin
         case ($urandom_range(0, 2))
            0:       stall_bits <= '0;
            1:       stall_bits <= 16'($urandom);
            default: stall_bits <= 16'($urandom | $urandom);
         endcase
      end else begin
         stall_bits <= {stall_bits[14:0], stall_bits[15]};
      end
      rsp_stall <= stall_bits[15];
   end

   always @(posedge clock) begin
      timing_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_timings.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_xfer_ticks, 32'd0);
         end else begin
            want = expected_timings.pop_front();
            if (rsp_xfer_ticks !== want.ticks)
               report_mismatch("xfer_ticks", rsp_xfer_ticks, want.ticks);
            if (rsp_done_res !== want.done)
               report_mismatch("done_res", {31'd0, rsp_done_res}, {31'd0, want.done});
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      lim_en         = RST_LIMIT_ENABLE;
      seek           = RST_SEEK_TICKS;
      disc_bpt       = RST_READ_BYTES_TICK;
      disc_tpb       = RST_READ_TICKS_BYTE;
      cache_tpb      = RST_CACHE_TICKS_BYTE;
      t_start        = '0;
      t_finish       = '0;
      ticks_owed     = ALL_ONES;
      window_base    = ALL_ONES;
      finished_block = ALL_ONES;

      add_typed(OP_END,   32'd0,     32'd0, 31'd0, 32'd0, 1'b1);
      add_typed(OP_START, 32'd100,   32'd0, 31'd0, 32'd0, 1'b0);
      add_typed(OP_MOTOR, 32'd200,   32'd0, 31'd0, 32'd0, 1'b0);
      add_typed(OP_END,   32'd300,   32'd0, 31'd0, 32'd0, 1'b0);
      add_typed(OP_END,   32'd95122, 32'd0, 31'd0, 32'd0, 1'b1);
      add_typed(OP_SETUP, 32'd1000,  32'd0, 31'd0, RST_SEEK_TICKS, 1'b0);
      add_row(OP_END,   32'd1000,       32'd0,          31'd0);
      add_row(OP_END,   32'd200000,     32'd0,          31'd0);
      add_row(OP_SETUP, 32'd200100,     32'h0001_0000,  31'h1000);
      add_row(OP_SETUP, 32'h0080_0000,  32'h0003_0000,  31'h2_0000);
      add_row(OP_SETUP, 32'hFFFF_FFFF,  32'h0005_0000,  31'h2_0000);
      add_row(OP_SETUP, 32'd100,        32'h0009_0000,  31'h1000);
      add_row(OP_SETUP, 32'd500,        32'hFFFF_FFFF,  31'h7FFF_FFFF);
      add_row(OP_START, 32'hFFFF_FFF0,  32'd0,          31'd0);
      add_row(OP_END,   32'd5,          32'd0,          31'd0);
      add_row(OP_END,   32'hFFFF_FFFF,  32'd0,          31'd0);
      add_cfg(REG_SEEK_TICKS, ALL_ONES);
      add_cfg(REG_READ_TICKS_BYTE, 32'h00FF_FFFF);
      add_row(OP_MOTOR, 32'd10,         32'd0,          31'd0);
      add_row(OP_SETUP, 32'd20,         32'd0,          31'h7FFF_FFFF);
      add_row(OP_END,   32'd30,         32'd0,          31'd0);
      add_cfg(REG_LIMIT_ENABLE, 32'd0);
      add_typed(OP_START, 32'd7,  32'd0,   31'd0,   32'd0, 1'b0);
      add_typed(OP_MOTOR, 32'd8,  32'd0,   31'd0,   32'd0, 1'b0);
      add_typed(OP_SETUP, 32'd9,  32'd123, 31'd999, 32'd0, 1'b0);
      add_typed(OP_END,   32'd10, 32'd0,   31'd0,   32'd0, 1'b1);
      add_cfg(REG_LIMIT_ENABLE, 32'd1);
      add_cfg(REG_READ_BYTES_TICK, 32'd0);
      add_cfg(REG_CACHE_TICKS_BYTE, 32'h00FF_FFFF);
      add_cfg(REG_SEEK_TICKS, 32'd0);
      add_cfg(REG_READ_TICKS_BYTE, 32'd0);
      add_row(OP_SETUP, 32'd40,         32'h0000_1000,  31'h100);
      add_row(OP_SETUP, 32'd50,         32'h0000_2000,  31'h3000);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) issue_command(directed_rows[i]);

      drive_now = $urandom;
      for (int ph = 0; ph < PHASES; ph++) begin
         program_phase(ph);
         while (items_sent < PHASE_ITEMS * (ph + 1) + directed_rows.size()) begin
            if ($urandom_range(0, 6) == 0)
               send_cmd(2'($urandom_range(0, 3)), $urandom, $urandom, 31'($urandom));
            else
               run_transfer();
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_timings.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d transactions over %0d register settings, %0d csr writes",
               items_sent, PHASES + 3, csr_writes);
      $display("setups in window %0d, outside %0d; end queries done %0d, waiting %0d",
               setups_hit, setups_missed, ends_done, ends_waiting);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", errors);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
